[design/cau_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types and constants of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  // Fraction bits of the fixed point format (valid range 8..24).
  localparam int unsigned FracBits = 16;
  // Quotient bits produced by the divider, one per stage.
  localparam int unsigned DivSteps = 32;

  typedef enum logic [2:0] {
    CmdAdd = 3'd0,
    CmdSub = 3'd1,
    CmdMul = 3'd2,
    CmdDiv = 3'd3,
    CmdCmp = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] a_real;
    logic signed [31:0] a_imag;
    logic signed [31:0] b_real;
    logic signed [31:0] b_imag;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_real;
    logic signed [31:0] result_imag;
    logic               is_equal;
    logic               divide_by_zero;
    logic               saturated;
  } res_t;

  // One divider lane: remainder, divisor, dividend/quotient shift word.
  typedef struct packed {
    logic        neg;
    logic        ovf;
    logic [63:0] rem;
    logic [63:0] den;
    logic [31:0] w;
  } lane_t;

endpackage

[design/cau_div_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_div_step
// One registered restoring division step: shifts in one dividend bit and
// produces one quotient bit.
// ----------------------------------------------------------------------------
module cau_div_step (
  input  logic           clk_i,
  input  logic           en_i,
  input  cau_pkg::lane_t lane_i,
  output cau_pkg::lane_t lane_o
);

  logic [64:0]    trial;
  logic           ge;
  cau_pkg::lane_t lane_d;
  cau_pkg::lane_t lane_q;

  always_comb begin
    trial  = {lane_i.rem, lane_i.w[31]};
    ge     = trial >= {1'b0, lane_i.den};
    lane_d = lane_i;
    lane_d.rem = ge ? 64'(trial - {1'b0, lane_i.den}) : trial[63:0];
    lane_d.w   = {lane_i.w[30:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

[design/complex_arithmetic_unit_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_top
// Pipelined complex add, subtract, multiply, divide and compare, Q16.16.
// ----------------------------------------------------------------------------
// A request is taken every cycle unless the input is stalled; results leave in
// request order. The divider resolves one quotient bit per stage over 32
// stages, after a multiply stage, a sum stage, a magnitude stage and a
// range-check stage, with one output register at the end. All commands
// travel the same path, so order is kept trivially. When the output holds a
// result and is stalled the whole pipeline freezes and the input stalls too;
// nothing is dropped or repeated.
module complex_arithmetic_unit_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cau_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output cau_pkg::res_t out_res_o
);

  localparam int unsigned NumStages = 4 + cau_pkg::DivSteps + 1;
  localparam int unsigned HiShift   = 32 - cau_pkg::FracBits;

  typedef struct packed {
    cau_pkg::cmd_e      cmd;
    logic signed [31:0] rr;
    logic signed [31:0] ri;
    logic               eq;
    logic               dz;
    logic               sat;
  } side_t;

  // Clamp a wide signed value to 32 bits: {saturated, value}.
  function automatic logic [32:0] clamp32(input logic signed [65:0] v);
    logic signed [65:0] max_v;
    logic signed [65:0] min_v;
    logic [32:0]        r;
    max_v = 66'sh7FFFFFFF;
    min_v = ~max_v;
    if (v > max_v) begin
      r = {1'b1, 32'h7FFFFFFF};
    end else if (v < min_v) begin
      r = {1'b1, 32'h80000000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // Apply sign and range to an unsigned quotient: {saturated, value}.
  function automatic logic [32:0] div_fmt(input cau_pkg::lane_t l);
    logic [32:0] r;
    if (l.ovf) begin
      r = {1'b1, (l.neg ? 32'h80000000 : 32'h7FFFFFFF)};
    end else if (l.neg) begin
      if (l.w > 32'h80000000) begin
        r = {1'b1, 32'h80000000};
      end else begin
        r = {1'b0, 32'(-l.w)};
      end
    end else if (l.w[31]) begin
      r = {1'b1, 32'h7FFFFFFF};
    end else begin
      r = {1'b0, l.w};
    end
    return r;
  endfunction

  logic en;
  logic [NumStages-1:0] valid_q;

  // global advance: frozen only while a finished result is held
  assign en          = !(valid_q[NumStages-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = valid_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[NumStages-2:0], in_valid_i};
    end
  end

  // ---- stage 1: products, add/sub, compare, zero divisor ----
  logic signed [63:0] p_arbr, p_aibi, p_arbi, p_aibr, p_brbr, p_bibi;
  logic signed [63:0] p_arbr_q, p_aibi_q, p_arbi_q, p_aibr_q, p_brbr_q, p_bibi_q;
  side_t side1_d;
  side_t side_q [NumStages-1];
  logic [32:0] cl_r, cl_i;

  assign p_arbr = in_req_i.a_real * in_req_i.b_real;
  assign p_aibi = in_req_i.a_imag * in_req_i.b_imag;
  assign p_arbi = in_req_i.a_real * in_req_i.b_imag;
  assign p_aibr = in_req_i.a_imag * in_req_i.b_real;
  assign p_brbr = in_req_i.b_real * in_req_i.b_real;
  assign p_bibi = in_req_i.b_imag * in_req_i.b_imag;

  always_comb begin
    side1_d = '0;
    side1_d.cmd = cau_pkg::cmd_e'(in_req_i.command);
    cl_r = '0;
    cl_i = '0;
    case (cau_pkg::cmd_e'(in_req_i.command))
      cau_pkg::CmdAdd: begin
        cl_r = clamp32(66'(in_req_i.a_real) + 66'(in_req_i.b_real));
        cl_i = clamp32(66'(in_req_i.a_imag) + 66'(in_req_i.b_imag));
      end
      cau_pkg::CmdSub: begin
        cl_r = clamp32(66'(in_req_i.a_real) - 66'(in_req_i.b_real));
        cl_i = clamp32(66'(in_req_i.a_imag) - 66'(in_req_i.b_imag));
      end
      cau_pkg::CmdDiv: begin
        side1_d.dz = (in_req_i.b_real == 32'sd0) && (in_req_i.b_imag == 32'sd0);
      end
      cau_pkg::CmdCmp: begin
        side1_d.eq = (in_req_i.a_real == in_req_i.b_real) &&
                     (in_req_i.a_imag == in_req_i.b_imag);
      end
      default: ;
    endcase
    side1_d.rr  = cl_r[31:0];
    side1_d.ri  = cl_i[31:0];
    side1_d.sat = cl_r[32] | cl_i[32];
  end

  // ---- stage 2: wide sums ----
  logic signed [65:0] mre_q, mim_q, nre_q, nim_q;
  logic [63:0]        den_q;

  // ---- stage 3: multiply rescale, divide magnitudes ----
  side_t       side3_d;
  logic [32:0] ms_r, ms_i;
  logic        neg_r_q, neg_i_q;
  logic [63:0] mag_r_q, mag_i_q, den3_q;

  always_comb begin
    side3_d = side_q[1];
    ms_r = clamp32(mre_q >>> cau_pkg::FracBits);
    ms_i = clamp32(mim_q >>> cau_pkg::FracBits);
    if (side_q[1].cmd == cau_pkg::CmdMul) begin
      side3_d.rr  = ms_r[31:0];
      side3_d.ri  = ms_i[31:0];
      side3_d.sat = ms_r[32] | ms_i[32];
    end
  end

  // ---- stage 4: range check and divider setup ----
  cau_pkg::lane_t lr [cau_pkg::DivSteps+1];
  cau_pkg::lane_t li [cau_pkg::DivSteps+1];
  cau_pkg::lane_t lr_d, li_d;
  cau_pkg::lane_t lr0_q, li0_q;

  always_comb begin
    lr_d.neg = neg_r_q;
    lr_d.den = den3_q;
    lr_d.rem = mag_r_q >> HiShift;
    lr_d.ovf = (mag_r_q >> HiShift) >= den3_q;
    lr_d.w   = mag_r_q[31:0] << cau_pkg::FracBits;
    li_d.neg = neg_i_q;
    li_d.den = den3_q;
    li_d.rem = mag_i_q >> HiShift;
    li_d.ovf = (mag_i_q >> HiShift) >= den3_q;
    li_d.w   = mag_i_q[31:0] << cau_pkg::FracBits;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_arbr_q <= p_arbr;
      p_aibi_q <= p_aibi;
      p_arbi_q <= p_arbi;
      p_aibr_q <= p_aibr;
      p_brbr_q <= p_brbr;
      p_bibi_q <= p_bibi;
      side_q[0] <= side1_d;

      mre_q <= 66'(p_arbr_q) - 66'(p_aibi_q);
      mim_q <= 66'(p_arbi_q) + 66'(p_aibr_q);
      nre_q <= 66'(p_arbr_q) + 66'(p_aibi_q);
      nim_q <= 66'(p_aibr_q) - 66'(p_arbi_q);
      den_q <= 64'(p_brbr_q) + 64'(p_bibi_q);
      side_q[1] <= side_q[0];

      neg_r_q <= nre_q < 66'sd0;
      neg_i_q <= nim_q < 66'sd0;
      mag_r_q <= (nre_q < 66'sd0) ? 64'(-nre_q) : nre_q[63:0];
      mag_i_q <= (nim_q < 66'sd0) ? 64'(-nim_q) : nim_q[63:0];
      den3_q  <= den_q;
      side_q[2] <= side3_d;

      lr0_q <= lr_d;
      li0_q <= li_d;
      for (int k = 3; k < NumStages - 1; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign lr[0] = lr0_q;
  assign li[0] = li0_q;

  // ---- stages 5..36: one quotient bit per stage, both lanes ----
  for (genvar g = 0; g < cau_pkg::DivSteps; g++) begin : g_div
    cau_div_step u_step_r (
      .clk_i  (clk_i),
      .en_i   (en),
      .lane_i (lr[g]),
      .lane_o (lr[g+1])
    );
    cau_div_step u_step_i (
      .clk_i  (clk_i),
      .en_i   (en),
      .lane_i (li[g]),
      .lane_o (li[g+1])
    );
  end

  // ---- output stage: result select ----
  side_t         side_last;
  logic [32:0]   dq_r, dq_i;
  cau_pkg::res_t res_d;
  cau_pkg::res_t res_q;

  assign side_last = side_q[NumStages-2];

  always_comb begin
    dq_r  = div_fmt(lr[cau_pkg::DivSteps]);
    dq_i  = div_fmt(li[cau_pkg::DivSteps]);
    res_d = '0;
    case (side_last.cmd)
      cau_pkg::CmdAdd, cau_pkg::CmdSub, cau_pkg::CmdMul: begin
        res_d.result_real = side_last.rr;
        res_d.result_imag = side_last.ri;
        res_d.saturated   = side_last.sat;
      end
      cau_pkg::CmdDiv: begin
        if (side_last.dz) begin
          res_d.divide_by_zero = 1'b1;
        end else begin
          res_d.result_real = dq_r[31:0];
          res_d.result_imag = dq_i[31:0];
          res_d.saturated   = dq_r[32] | dq_i[32];
        end
      end
      cau_pkg::CmdCmp: begin
        res_d.is_equal = side_last.eq;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  assign out_res_o = res_q;

endmodule

[tb/tb_complex_arithmetic_unit_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_complex_arithmetic_unit_top
// Self-checking bench for the pipelined complex arithmetic unit.
// ----------------------------------------------------------------------------
// Requests go in through a valid/stall port and results are checked in order
// against a fixed point predictor of add, subtract, multiply, divide and
// compare. A short directed table covers the extremes, every command, the
// zero denominator and the unused codes. A random phase follows, with idle
// and stall bursts on both sides, then a closing stretch without any.
// ----------------------------------------------------------------------------
module tb_complex_arithmetic_unit_top;
  import cau_pkg::*;

  localparam int NumRandom = 500;
  localparam int Latency   = 37;
  localparam logic signed [31:0] MaxQ = 32'sh7fffffff;
  localparam logic signed [31:0] MinQ = 32'sh80000000;
  localparam logic signed [31:0] OneQ = 32'sh00010000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  req_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  res_t out_res_o;

  res_t result_queue[$];
  int   fail_count = 0;
  int   results_seen = 0;
  int   cmd_count[8];
  bit   quiet = 1'b0;   // no idling or stalling near the end

  always #4 clk_i = ~clk_i;

  complex_arithmetic_unit_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o)
  );

  // Clamp a wide value into the 32 bit range, flagging saturation.
  function automatic logic signed [31:0] clamp_q(input logic signed [127:0] v,
                                                 inout logic sat);
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      return MaxQ;
    end
    if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return MinQ;
    end
    return v[31:0];
  endfunction

  // Golden complex unit. Wide signed math: multiply rescales by floor,
  // divide truncates the quotient toward zero.
  function automatic res_t cau_predict(input req_t r);
    res_t o;
    logic signed [127:0] ar, ai, br, bi, re, im, den, q;
    logic sat;
    o   = '0;
    sat = 1'b0;
    ar  = r.a_real;
    ai  = r.a_imag;
    br  = r.b_real;
    bi  = r.b_imag;
    case (r.command)
      CmdAdd: begin
        o.result_real = clamp_q(ar + br, sat);
        o.result_imag = clamp_q(ai + bi, sat);
      end
      CmdSub: begin
        o.result_real = clamp_q(ar - br, sat);
        o.result_imag = clamp_q(ai - bi, sat);
      end
      CmdMul: begin
        re = ar * br - ai * bi;
        im = ar * bi + ai * br;
        o.result_real = clamp_q(re >>> FracBits, sat);
        o.result_imag = clamp_q(im >>> FracBits, sat);
      end
      CmdDiv: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          o.divide_by_zero = 1'b1;
        end else begin
          re = (ar * br + ai * bi) <<< FracBits;
          im = (ai * br - ar * bi) <<< FracBits;
          q  = re / den;   // signed division truncates toward zero
          o.result_real = clamp_q(q, sat);
          q  = im / den;
          o.result_imag = clamp_q(q, sat);
        end
      end
      CmdCmp: o.is_equal = (r.a_real == r.b_real) && (r.a_imag == r.b_imag);
      default: ;
    endcase
    o.saturated = sat;
    return o;
  endfunction

  // Directed table: operands plus a hand-typed result where obvious.
  typedef struct {
    req_t req;
    bit   typed;
    res_t res;
  } vec_t;

  function automatic req_t mk(input logic [2:0] c, input logic signed [31:0] w,
                              x, y, z);
    req_t r;
    r.command = c;
    r.a_real  = w;
    r.a_imag  = x;
    r.b_real  = y;
    r.b_imag  = z;
    return r;
  endfunction

  function automatic res_t rs(input logic signed [31:0] re, im,
                              input logic eq, dz, sat);
    res_t o;
    o.result_real    = re;
    o.result_imag    = im;
    o.is_equal       = eq;
    o.divide_by_zero = dz;
    o.saturated      = sat;
    return o;
  endfunction

  vec_t directed[$];

  initial begin
    directed.push_back('{mk(CmdAdd, MaxQ, MinQ, MaxQ, MinQ), 1,
                         rs(MaxQ, MinQ, 0, 0, 1)});
    directed.push_back('{mk(CmdAdd, 0, 0, 0, 0), 1, rs(0, 0, 0, 0, 0)});
    directed.push_back('{mk(CmdAdd, -1, 5, 1, -5), 1, rs(0, 0, 0, 0, 0)});
    directed.push_back('{mk(CmdSub, MinQ, MaxQ, 1, -1), 1,
                         rs(MinQ, MaxQ, 0, 0, 1)});
    directed.push_back('{mk(CmdSub, MaxQ, MinQ, MaxQ, MinQ), 1,
                         rs(0, 0, 0, 0, 0)});
    directed.push_back('{mk(CmdMul, OneQ, 0, OneQ, 0), 1, rs(OneQ, 0, 0, 0, 0)});
    directed.push_back('{mk(CmdMul, MinQ, MinQ, MinQ, MinQ), 0, '0});
    directed.push_back('{mk(CmdMul, MaxQ, MinQ, MinQ, MaxQ), 0, '0});
    directed.push_back('{mk(CmdMul, -1, -1, 1, 1), 0, '0});
    directed.push_back('{mk(CmdDiv, OneQ, OneQ, 0, 0), 1, rs(0, 0, 0, 1, 0)});
    directed.push_back('{mk(CmdDiv, MaxQ, MinQ, 0, 0), 1, rs(0, 0, 0, 1, 0)});
    directed.push_back('{mk(CmdDiv, OneQ, 0, OneQ, 0), 1, rs(OneQ, 0, 0, 0, 0)});
    directed.push_back('{mk(CmdDiv, MaxQ, MaxQ, 1, 0), 1,
                         rs(MaxQ, MaxQ, 0, 0, 1)});
    directed.push_back('{mk(CmdDiv, MinQ, MinQ, MinQ, MinQ), 0, '0});
    directed.push_back('{mk(CmdDiv, MinQ, MaxQ, 1, 1), 0, '0});
    directed.push_back('{mk(CmdDiv, -3, 7, 2, -5), 0, '0});
    directed.push_back('{mk(CmdCmp, MaxQ, MinQ, MaxQ, MinQ), 1,
                         rs(0, 0, 1, 0, 0)});
    directed.push_back('{mk(CmdCmp, 1, 2, 1, 3), 1, rs(0, 0, 0, 0, 0)});
    directed.push_back('{mk(CmdCmp, 0, 0, 0, 0), 1, rs(0, 0, 1, 0, 0)});
    directed.push_back('{mk(3'd5, 1, 1, 1, 1), 1, rs(0, 0, 0, 0, 0)});
    directed.push_back('{mk(3'd6, MaxQ, MaxQ, 0, 0), 1, rs(0, 0, 0, 0, 0)});
    directed.push_back('{mk(3'd7, -1, -1, -1, -1), 1, rs(0, 0, 0, 0, 0)});
  end

  // Random operand: half modest values, some extremes, some full range.
  function automatic logic signed [31:0] rand_operand();
    case ($urandom_range(0, 9))
      0:       return MaxQ;
      1:       return MinQ;
      2:       return 0;
      3, 4:    return $urandom;
      default: return $signed($urandom_range(0, 32'h0007ffff)) - 32'sh00040000;
    endcase
  endfunction

  function automatic req_t rand_request();
    req_t r;
    r.command = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
    r.a_real = rand_operand();
    r.a_imag = rand_operand();
    r.b_real = rand_operand();
    r.b_imag = rand_operand();
    // Give compare and divide a fair share of equal and zero cases.
    if (r.command == CmdCmp && $urandom_range(0, 1)) begin
      r.b_real = r.a_real;
      if ($urandom_range(0, 2) != 0) r.b_imag = r.a_imag;
    end
    if (r.command == CmdDiv && $urandom_range(0, 9) == 0) begin
      r.b_real = 0;
      r.b_imag = 0;
    end
    return r;
  endfunction

  // Send one request; expectation is queued at the accepting edge.
  task automatic send_request(input req_t r, input bit typed, input res_t res);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (in_stall_o);
    result_queue.push_back(typed ? res : cau_predict(r));
    cmd_count[r.command]++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (result_queue.size() != 0) @(negedge clk_i);
  endtask

  // Stall bursts on the result side.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (result_queue.size() == 0) begin
        $error("unexpected result %p", out_res_o);
        fail_count++;
      end else begin
        res_t e;
        e = result_queue.pop_front();
        results_seen++;
        if (out_res_o.result_real !== e.result_real) begin
          $error("result_real exp %h got %h", e.result_real, out_res_o.result_real);
          fail_count++;
        end
        if (out_res_o.result_imag !== e.result_imag) begin
          $error("result_imag exp %h got %h", e.result_imag, out_res_o.result_imag);
          fail_count++;
        end
        if (out_res_o.is_equal !== e.is_equal) begin
          $error("is_equal exp %b got %b", e.is_equal, out_res_o.is_equal);
          fail_count++;
        end
        if (out_res_o.divide_by_zero !== e.divide_by_zero) begin
          $error("divide_by_zero exp %b got %b", e.divide_by_zero,
                 out_res_o.divide_by_zero);
          fail_count++;
        end
        if (out_res_o.saturated !== e.saturated) begin
          $error("saturated exp %b got %b", e.saturated, out_res_o.saturated);
          fail_count++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    int guard;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) send_request(directed[i].req, directed[i].typed,
                                       directed[i].res);
    // Hold off until the pipe has emptied once.
    wait_drained();

    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom - 60) quiet = 1'b1;
      send_request(rand_request(), 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    guard = 0;
    while (result_queue.size() != 0 && guard < 100000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (Latency + 5) @(negedge clk_i);

    $display("Covered %0d results: add %0d sub %0d mul %0d div %0d cmp %0d",
             results_seen, cmd_count[0], cmd_count[1], cmd_count[2],
             cmd_count[3], cmd_count[4]);
    $display("unused codes %0d, with idle and stall bursts on both ports",
             cmd_count[5] + cmd_count[6] + cmd_count[7]);
    if (fail_count == 0 && result_queue.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: worst case is far below this.
  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule

[sim.f]
design/cau_pkg.sv
design/cau_div_step.sv
design/complex_arithmetic_unit_top.sv
tb/tb_complex_arithmetic_unit_top.sv
